// ----- hw/rtl/savg_pkg.sv -----
// shared types, constants and helpers for the serial attribute video generator
package savg_pkg;

  localparam int RAM_WINDOW_DEPTH = 16384;
  localparam int RAM_AW = $clog2(RAM_WINDOW_DEPTH);
  localparam logic [16:0] RAM_DEPTH_W = 17'(RAM_WINDOW_DEPTH);
  localparam logic [16:0] WINDOW_BASE = 17'h08000;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [14:0] PERIOD_50 = 15'(312 * 64);
  localparam logic [14:0] PERIOD_60 = 15'(262 * 64);
  localparam logic [14:0] VS_START_50 = 15'(256 * 64);
  localparam logic [14:0] VS_START_60 = 15'(234 * 64);
  localparam logic [14:0] VS_END_50 = 15'(259 * 64);
  localparam logic [14:0] VS_END_60 = 15'(238 * 64);
  localparam logic [14:0] PIXEL_AREA_END = 15'(224 * 64);
  localparam logic [14:0] BITMAP_AREA_END = 15'(200 * 64);

  localparam logic [15:0] BITMAP_BASE = 16'ha000;
  localparam logic [15:0] TEXT_BASE = 16'hbb80;
  localparam logic [15:0] ROW_BYTES = 16'd40;

  localparam logic [5:0] COL_PIXEL_END = 6'd40;
  localparam logic [5:0] COL_SYNC_START = 6'd48;
  localparam logic [5:0] COL_BURST_START = 6'd54;
  localparam logic [5:0] COL_BLANK_START = 6'd56;

  // attribute groups, bits 4..3 of an attribute byte
  localparam logic [1:0] ATTR_INK = 2'd0;
  localparam logic [1:0] ATTR_CHARSET = 2'd1;
  localparam logic [1:0] ATTR_PAPER = 2'd2;
  localparam logic [1:0] ATTR_MODE = 2'd3;

  localparam logic [2:0] INK_RESET = 3'd7;
  localparam logic [2:0] PAPER_RESET = 3'd0;

  typedef enum logic [1:0] {
    KIND_PIXELS = 2'd0,
    KIND_BLANK  = 2'd1,
    KIND_SYNC   = 2'd2,
    KIND_BURST  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] col;
    logic [8:0] line;
    logic       bitmap;
  } tick_t;

  typedef struct packed {
    logic [7:0] ctl;
    logic [2:0] paper;
    logic [2:0] ink;
    logic       kill;
  } shade_t;

  function automatic logic [RAM_AW-1:0] ram_index(input logic [15:0] addr);
    logic [16:0] diff;
    diff = {1'b0, addr} - WINDOW_BASE;
    return diff[RAM_AW-1:0];
  endfunction

  // attribute colour codes are bit reversed into rgb
  function automatic logic [2:0] attr_colour(input logic [2:0] v);
    return {v[0], v[1], v[2]};
  endfunction

  // font base bits 15..10: graphics 0x9800/0x9c00, text 0xb400/0xb800
  function automatic logic [5:0] font_page(input logic gm, input logic alt);
    logic [5:0] page;
    if (gm) begin
      page = alt ? 6'h27 : 6'h26;
    end else begin
      page = alt ? 6'h2e : 6'h2d;
    end
    return page;
  endfunction

endpackage

// ----- hw/rtl/savg_vram.sv -----
// video ram: one write port, two registered read ports with enables
module savg_vram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [savg_pkg::RAM_AW-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic                       a_en,
  input  logic [savg_pkg::RAM_AW-1:0] a_addr,
  output logic [7:0]                 a_data,
  input  logic                       b_en,
  input  logic [savg_pkg::RAM_AW-1:0] b_addr,
  output logic [7:0]                 b_data
);

  logic [7:0] mem [savg_pkg::RAM_WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_data <= mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_data <= mem[b_addr];
    end
  end

endmodule

// ----- hw/rtl/savg_scan.sv -----
// scan position, frame rate and frame count; signal kind and first ram address
module savg_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_acc,
  input  logic                        gm_fwd,
  input  logic                        next_sixty,
  output savg_pkg::tick_t             tick,
  output logic [savg_pkg::RAM_AW-1:0] rd_addr,
  output logic                        blink_phase
);

  logic [14:0] pos_r, pos_nxt;
  logic        fis_r, fis_nxt;
  logic [5:0]  fcnt_r, fcnt_nxt;

  logic [5:0]  col;
  logic [8:0]  line;
  logic        frame_start;
  logic        fis_eff;
  logic [14:0] last_pos;
  logic [14:0] vs, ve;
  logic        bitmap;
  logic [15:0] bm_addr, txt_addr;

  assign col = pos_r[5:0];
  assign line = pos_r[14:6];
  assign frame_start = (pos_r == '0);
  assign fis_eff = frame_start ? next_sixty : fis_r;
  assign last_pos = (fis_eff ? savg_pkg::PERIOD_60 : savg_pkg::PERIOD_50) - 15'd1;
  assign vs = fis_r ? savg_pkg::VS_START_60 : savg_pkg::VS_START_50;
  assign ve = fis_r ? savg_pkg::VS_END_60 : savg_pkg::VS_END_50;
  assign bitmap = gm_fwd && (pos_r < savg_pkg::BITMAP_AREA_END);
  assign blink_phase = fcnt_r[5];

  assign bm_addr = savg_pkg::BITMAP_BASE + 16'(line) * savg_pkg::ROW_BYTES + 16'(col);
  assign txt_addr = savg_pkg::TEXT_BASE + 16'(pos_r[14:9]) * savg_pkg::ROW_BYTES
                    + 16'(col);
  assign rd_addr = savg_pkg::ram_index(bitmap ? bm_addr : txt_addr);

  always_comb begin
    tick.col = col;
    tick.line = line;
    tick.bitmap = bitmap;
    if (pos_r >= vs && pos_r < ve) begin
      tick.kind = savg_pkg::KIND_SYNC;
    end else if (pos_r < savg_pkg::PIXEL_AREA_END && col < savg_pkg::COL_PIXEL_END) begin
      tick.kind = savg_pkg::KIND_PIXELS;
    end else if (col < savg_pkg::COL_SYNC_START) begin
      tick.kind = savg_pkg::KIND_BLANK;
    end else if (col < savg_pkg::COL_BURST_START) begin
      tick.kind = savg_pkg::KIND_SYNC;
    end else if (col < savg_pkg::COL_BLANK_START) begin
      tick.kind = savg_pkg::KIND_BURST;
    end else begin
      tick.kind = savg_pkg::KIND_BLANK;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    fis_nxt = fis_r;
    fcnt_nxt = fcnt_r;
    if (tick_acc) begin
      pos_nxt = (pos_r == last_pos) ? '0 : pos_r + 15'd1;
      if (frame_start) begin
        fis_nxt = next_sixty;
        fcnt_nxt = fcnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fis_r <= 1'b0;
      fcnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      fis_r <= fis_nxt;
      fcnt_r <= fcnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/savg_attr.sv -----
// serial attribute state, font address and column colours
module savg_attr (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  savg_pkg::tick_t             tick,
  input  logic [7:0]                  ctl,
  input  logic                        blink_phase,
  output logic                        gm_fwd,
  output logic                        next_sixty,
  output logic [savg_pkg::RAM_AW-1:0] font_addr,
  output savg_pkg::shade_t            shade
);

  logic [2:0] ink_r, ink_nxt;
  logic [2:0] paper_r, paper_nxt;
  logic       alt_r, alt_nxt;
  logic       dh_r, dh_nxt;
  logic       blink_r, blink_nxt;
  logic       gm_r, gm_nxt;
  logic       n60_r, n60_nxt;
  logic       fgm_r, fgm_nxt;
  logic       falt_r, falt_nxt;

  logic       col0;
  logic       is_attr;
  logic [2:0] ink_e, paper_e;
  logic       alt_e, dh_e, blink_e, fgm_e, falt_e;
  logic [2:0] fl;
  logic [2:0] inv;

  assign col0 = (tick.col == '0);
  assign is_attr = (ctl[6:5] == 2'b00);

  // column zero restores the line defaults and relatches the font base
  assign ink_e = col0 ? savg_pkg::INK_RESET : ink_r;
  assign paper_e = col0 ? savg_pkg::PAPER_RESET : paper_r;
  assign alt_e = col0 ? 1'b0 : alt_r;
  assign dh_e = col0 ? 1'b0 : dh_r;
  assign blink_e = col0 ? 1'b0 : blink_r;
  assign fgm_e = col0 ? gm_r : fgm_r;
  assign falt_e = col0 ? 1'b0 : falt_r;

  assign fl = dh_e ? tick.line[3:1] : tick.line[2:0];
  assign font_addr = savg_pkg::ram_index({savg_pkg::font_page(fgm_e, falt_e), ctl[6:0], fl});

  always_comb begin
    ink_nxt = ink_e;
    paper_nxt = paper_e;
    alt_nxt = alt_e;
    dh_nxt = dh_e;
    blink_nxt = blink_e;
    gm_nxt = gm_r;
    n60_nxt = n60_r;
    fgm_nxt = fgm_e;
    falt_nxt = falt_e;
    if (is_attr) begin
      case (ctl[4:3])
        savg_pkg::ATTR_INK: begin
          ink_nxt = savg_pkg::attr_colour(ctl[2:0]);
        end
        savg_pkg::ATTR_CHARSET: begin
          alt_nxt = ctl[0];
          dh_nxt = ctl[1];
          blink_nxt = ctl[2];
          fgm_nxt = gm_r;
          falt_nxt = ctl[0];
        end
        savg_pkg::ATTR_PAPER: begin
          paper_nxt = savg_pkg::attr_colour(ctl[2:0]);
        end
        savg_pkg::ATTR_MODE: begin
          gm_nxt = ctl[2];
          n60_nxt = !ctl[1];
        end
        default: begin
          ink_nxt = ink_e;
        end
      endcase
    end
  end

  // the next column's first read is chosen before this column's update lands
  assign gm_fwd = upd ? gm_nxt : gm_r;
  assign next_sixty = n60_r;

  assign inv = {3{ctl[7]}};
  assign shade.ctl = ctl;
  assign shade.paper = paper_nxt ^ inv;
  assign shade.ink = (is_attr ? paper_nxt : ink_e) ^ inv;
  assign shade.kill = blink_e && blink_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ink_r <= savg_pkg::INK_RESET;
      paper_r <= savg_pkg::PAPER_RESET;
      alt_r <= 1'b0;
      dh_r <= 1'b0;
      blink_r <= 1'b0;
      gm_r <= 1'b0;
      n60_r <= 1'b0;
      fgm_r <= 1'b0;
      falt_r <= 1'b0;
    end else if (upd) begin
      ink_r <= ink_nxt;
      paper_r <= paper_nxt;
      alt_r <= alt_nxt;
      dh_r <= dh_nxt;
      blink_r <= blink_nxt;
      gm_r <= gm_nxt;
      n60_r <= n60_nxt;
      fgm_r <= fgm_nxt;
      falt_r <= falt_nxt;
    end
  end

endmodule

// ----- hw/rtl/serial_attribute_video_generator.sv -----
// top level: three-stage read pipeline around the video ram and the result register
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_cmd, in_mem_address, in_mem_data
//   out_     output     out_valid / out_ready signal_kind, pixel_0..5, column, line
//
// one word per cycle is accepted while in_ready is high; a tick's result reaches the output
// register through the stages (cell read at acceptance, font read, then colour formation)
// the two dependent reads use separate read ports of the video ram
// reset clears the scan and attribute state and the stage valid flags; the video ram is not cleared
// a stalled result backs up through the stages, two further ticks fit before in_ready drops
module serial_attribute_video_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_mem_address,
  input  logic [7:0]  in_mem_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_signal_kind,
  output logic [2:0]  out_pixel_0,
  output logic [2:0]  out_pixel_1,
  output logic [2:0]  out_pixel_2,
  output logic [2:0]  out_pixel_3,
  output logic [2:0]  out_pixel_4,
  output logic [2:0]  out_pixel_5,
  output logic [5:0]  out_column_index,
  output logic [8:0]  out_line_index
);

  logic out_en, st2_en, st1_en;
  logic in_acc, tick_acc, wr_acc;

  logic            st1_v_r, st1_v_nxt;
  savg_pkg::tick_t st1_tick_r;
  logic            st2_v_r, st2_v_nxt;
  savg_pkg::tick_t st2_tick_r;
  savg_pkg::shade_t st2_shade_r;
  logic            out_v_r, out_v_nxt;

  logic [1:0] kind_r;
  logic [2:0] pix_r [6];
  logic [5:0] col_r;
  logic [8:0] line_r;

  savg_pkg::tick_t  scan_tick;
  savg_pkg::shade_t shade;
  logic [savg_pkg::RAM_AW-1:0] rd_addr, font_addr, wr_addr;
  logic [7:0]  a_data, b_data;
  logic        gm_fwd, next_sixty, blink_phase, attr_upd;
  logic [16:0] wr_off;
  logic        wr_in_window;
  logic [7:0]  pix_bits;
  logic [2:0]  pix_col [6];

  assign out_en = !out_v_r || out_ready;
  assign st2_en = !st2_v_r || out_en;
  assign st1_en = !st1_v_r || st2_en;
  assign in_ready = st1_en;
  assign in_acc = in_valid && in_ready;
  assign tick_acc = in_acc && (in_cmd == savg_pkg::CMD_TICK);
  assign wr_acc = in_acc && (in_cmd == savg_pkg::CMD_WRITE);

  assign wr_off = {1'b0, in_mem_address} - savg_pkg::WINDOW_BASE;
  assign wr_in_window = in_mem_address[15] && (wr_off < savg_pkg::RAM_DEPTH_W);
  assign wr_addr = wr_off[savg_pkg::RAM_AW-1:0];

  assign attr_upd = st1_v_r && st2_en && (st1_tick_r.kind == savg_pkg::KIND_PIXELS);

  savg_vram u_vram (
    .clk    (clk),
    .we     (wr_acc && wr_in_window),
    .waddr  (wr_addr),
    .wdata  (in_mem_data),
    .a_en   (st1_en),
    .a_addr (rd_addr),
    .a_data (a_data),
    .b_en   (st2_en),
    .b_addr (font_addr),
    .b_data (b_data)
  );

  savg_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_acc    (tick_acc),
    .gm_fwd      (gm_fwd),
    .next_sixty  (next_sixty),
    .tick        (scan_tick),
    .rd_addr     (rd_addr),
    .blink_phase (blink_phase)
  );

  savg_attr u_attr (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (attr_upd),
    .tick        (st1_tick_r),
    .ctl         (a_data),
    .blink_phase (blink_phase),
    .gm_fwd      (gm_fwd),
    .next_sixty  (next_sixty),
    .font_addr   (font_addr),
    .shade       (shade)
  );

  // bitmap columns take the cell byte, text columns the font byte
  assign pix_bits = (st2_tick_r.bitmap ? st2_shade_r.ctl : b_data)
                    & {8{!st2_shade_r.kill}};

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (st2_tick_r.kind != savg_pkg::KIND_PIXELS) begin
        pix_col[i] = '0;
      end else if (pix_bits[5-i]) begin
        pix_col[i] = st2_shade_r.ink;
      end else begin
        pix_col[i] = st2_shade_r.paper;
      end
    end
  end

  always_comb begin
    st1_v_nxt = st1_v_r;
    st2_v_nxt = st2_v_r;
    out_v_nxt = out_v_r;
    if (st1_en) begin
      st1_v_nxt = tick_acc;
    end
    if (st2_en) begin
      st2_v_nxt = st1_v_r;
    end
    if (out_en) begin
      out_v_nxt = st2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
      st2_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st1_v_r <= st1_v_nxt;
      st2_v_r <= st2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_en) begin
      st1_tick_r <= scan_tick;
    end
    if (st2_en) begin
      st2_tick_r <= st1_tick_r;
      st2_shade_r <= shade;
    end
    if (out_en && st2_v_r) begin
      kind_r <= st2_tick_r.kind;
      col_r <= st2_tick_r.col;
      line_r <= st2_tick_r.line;
      for (int i = 0; i < 6; i++) begin
        pix_r[i] <= pix_col[i];
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_signal_kind = kind_r;
  assign out_pixel_0 = pix_r[0];
  assign out_pixel_1 = pix_r[1];
  assign out_pixel_2 = pix_r[2];
  assign out_pixel_3 = pix_r[3];
  assign out_pixel_4 = pix_r[4];
  assign out_pixel_5 = pix_r[5];
  assign out_column_index = col_r;
  assign out_line_index = line_r;

endmodule
